[design/coalescing_event_queue_defines.svh]
// ----------------------------------------------------------------------------
// coalescing event queue assertion macros
// shared property shapes for the queue checks
// ----------------------------------------------------------------------------
`ifndef COALESCING_EVENT_QUEUE_DEFINES_SVH
`define COALESCING_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication
`define CEQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coalescing event queue: check failed");

// next-cycle implication
`define CEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coalescing event queue: check failed");

`endif

[design/ceq_pkg.sv]
// ----------------------------------------------------------------------------
// ceq_pkg
// types and constants shared by the coalescing event queue and its cells
// ----------------------------------------------------------------------------
package ceq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int CAP_W           = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 4;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_DRAIN = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;

   localparam logic [1:0] KIND_PROGRESS = 2'd0;
   localparam logic [1:0] KIND_MESSAGE  = 2'd1;
   localparam logic [1:0] KIND_CRITICAL = 2'd2;
   localparam logic [1:0] KIND_OTHER    = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] dataset;
      logic [31:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_MERGE   = 3'd1,
      OP_APPEND  = 3'd2,
      OP_COMPACT = 3'd3,
      OP_SHIFT   = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_cmd_type;

   // running status passed from the oldest cell towards the newest
   typedef struct packed {
      logic prog;
      logic hit;
   } chain_type;

endpackage

[design/ceq_cell.sv]
// ----------------------------------------------------------------------------
// ceq_cell
// one queue slot: key compare, oldest-progress chain and shift towards head
// ----------------------------------------------------------------------------
module ceq_cell #(
   parameter int DEPTH = ceq_pkg::QUEUE_DEPTH_DEF,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  ceq_pkg::cell_cmd_type      cmd_i,
   input  logic [$clog2(DEPTH+1)-1:0] count_i,
   input  ceq_pkg::chain_type         chain_i,
   output ceq_pkg::chain_type         chain_o,
   input  ceq_pkg::entry_type         next_i,
   output ceq_pkg::entry_type         entry_o
);
   import ceq_pkg::*;

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] IDX     = CW'(INDEX);
   localparam logic [CW-1:0] LASTPOS = CW'(INDEX + 1);

   entry_type entry_ff, entry_in;
   logic      occ, is_prog, match;

   assign occ     = IDX < count_i;
   assign is_prog = occ && (entry_ff.kind == KIND_PROGRESS);
   assign match   = is_prog && (entry_ff.dataset == cmd_i.entry.dataset);

   assign chain_o.prog = chain_i.prog | is_prog;
   assign chain_o.hit  = chain_i.hit | match;
   assign entry_o      = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd_i.op)
         OP_MERGE: begin
            if (match) entry_in.payload = cmd_i.entry.payload;
         end
         OP_APPEND: begin
            if (IDX == count_i) entry_in = cmd_i.entry;
         end
         OP_COMPACT: begin
            // slots from the removed progress item onwards move up one
            if (count_i == LASTPOS) entry_in = cmd_i.entry;
            else if (occ && chain_o.prog) entry_in = next_i;
         end
         OP_SHIFT: begin
            entry_in = next_i;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[design/coalescing_event_queue.sv]
// coalescing event queue, top level
// push: accept, then the scan and apply states; the result is registered in apply, next item taken back in idle
// close and unused action: the result is registered in the reply state, then the queue returns to idle
// drain: results are registered in the drain state, one per cycle while the receiver does not stall, then idle
// a stalled result register holds the apply, drain and reply states; one item at a time
// synchronous active-high reset empties the queue, clears loss and closed, capacity to the depth
// ----------------------------------------------------------------------------
// coalescing_event_queue
// bounded in-order event queue with in-place progress coalescing
// ----------------------------------------------------------------------------
`include "coalescing_event_queue_defines.svh"

module coalescing_event_queue #(
   parameter int QUEUE_DEPTH = ceq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // dataset_id [15:0], payload [47:16]
   input  logic [ceq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action [1:0], event_kind [3:2]
   input  logic [ceq_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // accepted [0], out_dataset [16:1], out_payload [48:17], zero fill [55:49]
   output logic [ceq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // has_event [0], is_loss_marker [1], out_kind [3:2]
   output logic [ceq_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic [ceq_pkg::CAP_W-1:0]       csr_wr_data
);
   import ceq_pkg::*;

   localparam int CW   = $clog2(QUEUE_DEPTH+1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_APPLY = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   entry_type       cmd_ff, cmd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            loss_ff, loss_in;
   logic            closed_ff, closed_in;
   logic [CMPW-1:0] cap_ff;
   logic            hit_ff, prog_ff, full_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic            rsp_last_ff, rsp_last_in;

   cell_cmd_type    cell_cmd;
   chain_type       chain [QUEUE_DEPTH+1];
   entry_type       ent [QUEUE_DEPTH];

   logic            req_accept, slot_free, full_now;
   logic [CMPW-1:0] eff_cap, cap_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // capacity clamp: zero counts as one, above the depth counts as the depth
   assign cap_ext = cap_ff;
   always_comb begin
      if (cap_ff == '0) eff_cap = CMPW'(1);
      else if (cap_ext > CMPW'(QUEUE_DEPTH)) eff_cap = CMPW'(QUEUE_DEPTH);
      else eff_cap = cap_ext;
   end
   assign full_now = CMPW'(count_ff) >= eff_cap;

   assign chain[0] = '0;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_type nb;
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign nb = cmd_ff;
      end else begin : g_body
         assign nb = ent[g+1];
      end
      ceq_cell #(
         .DEPTH (QUEUE_DEPTH),
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .cmd_i   (cell_cmd),
         .count_i (count_ff),
         .chain_i (chain[g]),
         .chain_o (chain[g+1]),
         .next_i  (nb),
         .entry_o (ent[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      loss_in      = loss_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      cell_cmd.op    = OP_HOLD;
      cell_cmd.entry = cmd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in.kind    = req_tuser[3:2];
               cmd_in.dataset = req_tdata[15:0];
               cmd_in.payload = req_tdata[47:16];
               case (req_tuser[1:0])
                  ACT_PUSH:  state_in = ST_SCAN;
                  ACT_DRAIN: state_in = ST_DRAIN;
                  ACT_CLOSE: begin
                     closed_in = 1'b1;
                     state_in  = ST_REPLY;
                  end
                  default:   state_in = ST_REPLY;
               endcase
            end
         end
         ST_SCAN: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (!closed_ff) begin
                  if (cmd_ff.kind == KIND_PROGRESS) begin
                     if (hit_ff) begin
                        rsp_data_in[0] = 1'b1;
                        cell_cmd.op    = OP_MERGE;
                     end else if (!full_ff) begin
                        rsp_data_in[0] = 1'b1;
                        cell_cmd.op    = OP_APPEND;
                        count_in       = count_ff + CW'(1);
                     end else if (prog_ff) begin
                        rsp_data_in[0] = 1'b1;
                        cell_cmd.op    = OP_COMPACT;
                     end
                  end else if (!full_ff) begin
                     rsp_data_in[0] = 1'b1;
                     cell_cmd.op    = OP_APPEND;
                     count_in       = count_ff + CW'(1);
                  end else if (cmd_ff.kind == KIND_CRITICAL) begin
                     loss_in = 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               if (loss_ff) begin
                  rsp_user_in = {KIND_CRITICAL, 1'b1, 1'b1};
                  rsp_last_in = (count_ff == '0);
                  loss_in     = 1'b0;
                  if (count_ff == '0) state_in = ST_IDLE;
               end else if (count_ff == '0) begin
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_data_in = {7'b0, ent[0].payload, ent[0].dataset, 1'b0};
                  rsp_user_in = {ent[0].kind, 1'b0, 1'b1};
                  rsp_last_in = (count_ff == CW'(1));
                  cell_cmd.op = OP_SHIFT;
                  count_in    = count_ff - CW'(1);
                  if (count_ff == CW'(1)) state_in = ST_IDLE;
               end
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         loss_ff      <= 1'b0;
         closed_ff    <= 1'b0;
         cap_ff       <= CMPW'(QUEUE_DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         loss_ff      <= loss_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) cap_ff <= CMPW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      // scan results, only meaningful for a push
      hit_ff  <= (cmd_ff.kind == KIND_PROGRESS) && chain[QUEUE_DEPTH].hit;
      prog_ff <= chain[QUEUE_DEPTH].prog;
      full_ff <= full_now;
   end

   `CEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, CMPW'(count_ff) <= CMPW'(QUEUE_DEPTH))
   `CEQ_ASSERT_NEXT(a_idle_count_hold, clock, reset, state_ff == ST_IDLE, $stable(count_ff))
   `CEQ_ASSERT_NEXT(a_marker_clears_loss, clock, reset, state_ff == ST_DRAIN && slot_free && loss_ff, !loss_ff)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the coalescing event queue: a mirror of the queue
// state predicts every result item, which is checked field by field against
// the response stream under random stalls and capacity changes
// ----------------------------------------------------------------------------
module tb;

   import ceq_pkg::*;

   localparam logic [1:0] ACT_SPARE  = 2'd3;
   localparam int         CYCLE_CAP  = 500000;
   localparam int         DRAIN_WAIT = 20;

   typedef struct packed {
      logic        accepted;
      logic        has_event;
      logic        loss_marker;
      logic [1:0]  kind;
      logic [15:0] dataset;
      logic [31:0] payload;
      logic        is_last;
   } rsp_item_type;

   // mirror of the queue and the responses it still owes
   class queue_scoreboard;
      entry_type        slots[QUEUE_DEPTH_DEF];
      int unsigned      held;
      bit               loss_flag;
      bit               closed_flag;
      logic [CAP_W-1:0] capacity;
      rsp_item_type     due_results[$];
      int               fails;

      function new();
         held        = 0;
         loss_flag   = 1'b0;
         closed_flag = 1'b0;
         capacity    = CAP_RESET;
         fails       = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function int unsigned room();
         if (capacity == 0) return 1;
         if (capacity > QUEUE_DEPTH_DEF) return QUEUE_DEPTH_DEF;
         return 32'(capacity);
      endfunction

      function void store_entry(logic [1:0] kind, logic [15:0] ds, logic [31:0] pl);
         if (held < QUEUE_DEPTH_DEF) begin
            slots[held] = '{kind: kind, dataset: ds, payload: pl};
            held++;
         end
      endfunction

      function bit push_event(logic [1:0] kind, logic [15:0] ds, logic [31:0] pl);
         int unsigned cap;
         int unsigned i;
         cap = room();
         if (closed_flag) return 1'b0;
         if (kind == KIND_PROGRESS) begin
            for (i = 0; i < held; i++) begin
               if (slots[i].kind == KIND_PROGRESS && slots[i].dataset == ds) begin
                  slots[i].payload = pl;
                  return 1'b1;
               end
            end
            if (held >= cap) begin
               // evict the oldest progress entry to make room
               i = 0;
               while (i < held && slots[i].kind != KIND_PROGRESS) i++;
               if (i >= held) return 1'b0;
               for (; i + 1 < held; i++) slots[i] = slots[i+1];
               held--;
            end
            store_entry(kind, ds, pl);
            return 1'b1;
         end
         if (held < cap) begin
            store_entry(kind, ds, pl);
            return 1'b1;
         end
         if (kind == KIND_CRITICAL) loss_flag = 1'b1;
         return 1'b0;
      endfunction

      function void add_result(logic acc, logic has, logic loss, logic [1:0] kind,
                               logic [15:0] ds, logic [31:0] pl, logic lst);
         rsp_item_type r;
         r = '{accepted: acc, has_event: has, loss_marker: loss, kind: kind,
               dataset: ds, payload: pl, is_last: lst};
         due_results.push_back(r);
      endfunction

      function void note_item(logic [1:0] action, logic [1:0] kind,
                              logic [15:0] ds, logic [31:0] pl);
         int unsigned total;
         int unsigned n;
         int unsigned i;
         case (action)
            ACT_PUSH: begin
               add_result(push_event(kind, ds, pl), 1'b0, 1'b0, 2'd0, 16'd0, 32'd0, 1'b1);
            end
            ACT_DRAIN: begin
               total = held + (loss_flag ? 1 : 0);
               if (total == 0) begin
                  add_result(1'b0, 1'b0, 1'b0, 2'd0, 16'd0, 32'd0, 1'b1);
               end else begin
                  n = 0;
                  if (loss_flag) begin
                     add_result(1'b0, 1'b1, 1'b1, KIND_CRITICAL, 16'd0, 32'd0, total == 1);
                     n = 1;
                     loss_flag = 1'b0;
                  end
                  for (i = 0; i < held; i++) begin
                     add_result(1'b0, 1'b1, 1'b0, slots[i].kind, slots[i].dataset,
                                slots[i].payload, n + 1 == total);
                     n++;
                  end
                  held = 0;
               end
            end
            ACT_CLOSE: begin
               closed_flag = 1'b1;
               add_result(1'b0, 1'b0, 1'b0, 2'd0, 16'd0, 32'd0, 1'b1);
            end
            default: begin
               add_result(1'b0, 1'b0, 1'b0, 2'd0, 16'd0, 32'd0, 1'b1);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fails++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user,
                                 logic lst);
         rsp_item_type want;
         if (due_results.size() == 0) begin
            $display("%0t: result item with nothing due, expected none actual %h %h %b",
                     $time, data, user, lst);
            fails++;
            return;
         end
         want = due_results[0];
         due_results.delete(0);
         compare_field("accepted", 32'(want.accepted), 32'(data[0]));
         compare_field("out_dataset", 32'(want.dataset), 32'(data[16:1]));
         compare_field("out_payload", want.payload, data[48:17]);
         compare_field("has_event", 32'(want.has_event), 32'(user[0]));
         compare_field("is_loss_marker", 32'(want.loss_marker), 32'(user[1]));
         compare_field("out_kind", 32'(want.kind), 32'(user[3:2]));
         compare_field("last", 32'(want.is_last), 32'(lst));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CAP_W-1:0]      csr_wr_data = '0;

   queue_scoreboard sb = new();
   bit              quiet = 0;
   int              stall_left = 0;
   int              cycles = 0;

   coalescing_event_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_tready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic [1:0] action, logic [1:0] kind, logic [15:0] ds,
                            logic [31:0] pl);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {pl, ds};
      req_tuser  = {kind, action};
      do @(posedge clock); while (!req_tready);
      sb.note_item(action, kind, ds, pl);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      sb.set_capacity(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_item(bit allow_close);
      logic [1:0]  action;
      logic [1:0]  kind;
      logic [15:0] ds;
      logic [31:0] pl;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)                      action = ACT_DRAIN;
      else if (pick < 13)                 action = ACT_SPARE;
      else if (pick < 15 && allow_close)  action = ACT_CLOSE;
      else                                action = ACT_PUSH;
      pick = $urandom_range(0, 19);
      if (pick < 9)       kind = KIND_PROGRESS;
      else if (pick < 13) kind = KIND_MESSAGE;
      else if (pick < 16) kind = KIND_CRITICAL;
      else                kind = KIND_OTHER;
      // a narrow key pool so that progress items coalesce often
      case ($urandom_range(0, 9))
         0:       ds = 16'($urandom);
         1:       ds = 16'hFFFF;
         default: ds = 16'($urandom_range(0, 5));
      endcase
      case ($urandom_range(0, 15))
         0:       pl = 32'd0;
         1:       pl = 32'hFFFF_FFFF;
         default: pl = $urandom;
      endcase
      send_item(action, kind, ds, pl);
   endtask

   initial begin
      logic [CAP_W-1:0] caps[10];
      int               p;
      int               k;
      caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd17, 5'd8, 5'd0, 5'd3, 5'd2};
      caps[7] = CAP_W'($urandom_range(0, 31));
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      send_item(ACT_DRAIN, KIND_PROGRESS, 16'd0, 32'd0);
      send_item(ACT_SPARE, KIND_OTHER, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd0, 32'd0);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd0, 32'h1234_5678);
      send_item(ACT_PUSH, KIND_MESSAGE, 16'hFFFF, 32'd1);
      send_item(ACT_PUSH, KIND_CRITICAL, 16'd7, 32'hDEAD_BEEF);
      send_item(ACT_PUSH, KIND_OTHER, 16'd5, 32'hAAAA_5555);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd5, 32'h5555_AAAA);
      send_item(ACT_DRAIN, KIND_PROGRESS, 16'd0, 32'd0);
      set_capacity(5'd2);
      send_item(ACT_PUSH, KIND_MESSAGE, 16'd1, 32'h0000_0011);
      send_item(ACT_PUSH, KIND_MESSAGE, 16'd2, 32'h0000_0022);
      // a full queue loses criticals, but only one marker is kept
      send_item(ACT_PUSH, KIND_CRITICAL, 16'd3, 32'h0000_0033);
      send_item(ACT_PUSH, KIND_CRITICAL, 16'd4, 32'h0000_0044);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd9, 32'h0000_0099);
      send_item(ACT_DRAIN, KIND_PROGRESS, 16'd0, 32'd0);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd1, 32'h0000_0101);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd2, 32'h0000_0202);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd3, 32'h0000_0303);
      send_item(ACT_PUSH, KIND_MESSAGE, 16'd4, 32'h0000_0404);
      send_item(ACT_DRAIN, KIND_PROGRESS, 16'd0, 32'd0);
      set_capacity(5'd16);
      send_item(ACT_PUSH, KIND_MESSAGE, 16'd1, 32'h0000_1111);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd2, 32'h0000_2222);
      send_item(ACT_PUSH, KIND_OTHER, 16'd3, 32'h0000_3333);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd4, 32'h0000_4444);
      // capacity below the entry count: progress push keeps the count
      set_capacity(5'd2);
      send_item(ACT_PUSH, KIND_PROGRESS, 16'd8, 32'h0000_8888);
      send_item(ACT_PUSH, KIND_OTHER, 16'd8, 32'h0000_9999);
      send_item(ACT_DRAIN, KIND_PROGRESS, 16'd0, 32'd0);

      // random part, a run of items per capacity setting
      for (p = 0; p < 10; p++) begin
         set_capacity(caps[p]);
         for (k = 0; k < 26; k++) random_item(0);
      end

      // closing phase with no idling on either side
      set_capacity(CAP_W'($urandom_range(4, 16)));
      quiet = 1;
      for (k = 0; k < 10; k++) random_item(0);
      send_item(ACT_CLOSE, KIND_PROGRESS, 16'd0, 32'd0);
      for (k = 0; k < 20; k++) random_item(1);
      send_item(ACT_DRAIN, KIND_PROGRESS, 16'd0, 32'd0);

      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
